/* rtl/assert_macros.svh */
// Assertion helper macros shared by the path open list RTL.
// Users need a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define POLT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define POLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/polt_pkg.sv */
// Shared types and constants for the path open list table.
// No dependencies.
package polt_pkg;

  localparam int KEY_W   = 16;
  localparam int COST_W  = 31;
  localparam int TOTAL_W = 7;

  localparam logic [COST_W-1:0] COST_LIMIT = 31'd999999999;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_MIN    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_FIND,
    S_MIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               found;
    logic [KEY_W-1:0]   hit_x;
    logic [KEY_W-1:0]   hit_y;
    logic [COST_W-1:0]  hit_cost;
    logic [TOTAL_W-1:0] entry_total;
    logic               status;
  } rsp_word_t;

endpackage

/* rtl/polt_req_if.sv */
// Request channel of the path open list table: valid/ready plus command word.
// Depends on polt_pkg.
interface polt_req_if import polt_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               opcode;
  logic [KEY_W-1:0]  key_x;
  logic [KEY_W-1:0]  key_y;
  logic [COST_W-1:0] cost_f;

  modport source (output valid, opcode, key_x, key_y, cost_f, input ready);
  modport sink   (input valid, opcode, key_x, key_y, cost_f, output ready);
endinterface

/* rtl/polt_rsp_if.sv */
// Response channel of the path open list table: valid/ready plus result word.
// Depends on polt_pkg.
interface polt_rsp_if import polt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [KEY_W-1:0]   hit_x;
  logic [KEY_W-1:0]   hit_y;
  logic [COST_W-1:0]  hit_cost;
  logic [TOTAL_W-1:0] entry_total;
  logic               status;

  modport source (output valid, found, hit_x, hit_y, hit_cost, entry_total, status,
                  input ready);
  modport sink   (input valid, found, hit_x, hit_y, hit_cost, entry_total, status,
                  output ready);
endinterface

/* rtl/polt_ctrl.sv */
// Entry memory and scan sequencer: append, compacting remove, lookup, find-min.
// Depends on polt_pkg and polt_req_if.
module polt_ctrl import polt_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  polt_req_if.sink   req,
  output rsp_word_t  res,
  output logic       res_valid,
  input  logic       res_ready
);

  localparam int KW = (COORD_BITS < KEY_W) ? COORD_BITS : KEY_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [KW-1:0]     x;
    logic [KW-1:0]     y;
    logic [COST_W-1:0] cost;
  } entry_t;

  entry_t mem [CAPACITY];
  entry_t rdata;
  entry_t hit;
  entry_t wr_data;

  state_t            state, state_next;
  logic [CW-1:0]     count, iss, wptr;
  logic [KW-1:0]     kx, ky;
  logic [COST_W-1:0] best;
  logic              rd_vld, have, hit_found, status;
  logic              accept, scanning, scan_more, scan_end, match, full, do_append;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  assign accept    = req.valid && req.ready;
  assign scanning  = (state == S_REMOVE) || (state == S_FIND) || (state == S_MIN);
  assign scan_more = iss < count;
  assign scan_end  = !scan_more && !rd_vld;
  assign match     = rd_vld && (rdata.x == kx) && (rdata.y == ky);
  assign full      = count == CW'(CAPACITY);
  assign do_append = (state == S_IDLE) && accept && (req.opcode == OP_APPEND) && !full;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr[AW-1:0];
    wr_data = rdata;
    if (do_append) begin
      wr_en   = 1'b1;
      wr_addr = count[AW-1:0];
      wr_data = '{x: req.key_x[KW-1:0], y: req.key_y[KW-1:0], cost: req.cost_f};
    end else if ((state == S_REMOVE) && rd_vld && !match) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (scanning && scan_more) begin
      rdata <= mem[iss[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          unique case (req.opcode)
            OP_APPEND: state_next = S_DONE;
            OP_REMOVE: state_next = S_REMOVE;
            OP_GET:    state_next = S_FIND;
            OP_MIN:    state_next = S_MIN;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_REMOVE: if (scan_end) state_next = S_DONE;
      S_FIND:   if (scan_end) state_next = S_DONE;
      S_MIN:    if (scan_end) state_next = have ? S_FIND : S_DONE;
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= scanning && scan_more;
      if (do_append) begin
        count <= count + CW'(1);
      end else if ((state == S_REMOVE) && scan_end) begin
        count <= wptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && accept) begin
      kx        <= req.key_x[KW-1:0];
      ky        <= req.key_y[KW-1:0];
      iss       <= '0;
      wptr      <= '0;
      hit       <= '0;
      hit_found <= 1'b0;
      best      <= COST_LIMIT;
      have      <= 1'b0;
      status    <= (req.opcode == OP_APPEND) && full;
    end else begin
      if (scanning && scan_more) begin
        iss <= iss + CW'(1);
      end
      if ((state == S_REMOVE) && rd_vld && !match) begin
        wptr <= wptr + CW'(1);
      end
      if ((state == S_FIND) && match && !hit_found) begin
        hit_found <= 1'b1;
        hit       <= rdata;
      end
      if ((state == S_MIN) && rd_vld && (rdata.cost < best)) begin
        best <= rdata.cost;
        have <= 1'b1;
        kx   <= rdata.x;
        ky   <= rdata.y;
      end
      // second pass looks up the first entry with the winning key
      if ((state == S_MIN) && scan_end) begin
        iss <= '0;
      end
    end
  end

  assign res.found       = hit_found;
  assign res.hit_x       = KEY_W'(hit.x);
  assign res.hit_y       = KEY_W'(hit.y);
  assign res.hit_cost    = hit.cost;
  assign res.entry_total = TOTAL_W'(count);
  assign res.status      = status;

endmodule

/* rtl/polt_outreg.sv */
// Output register holding one result word until the receiver takes it.
// Depends on polt_pkg and polt_rsp_if.
module polt_outreg import polt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rsp_word_t  res,
  input  logic       res_valid,
  output logic       res_ready,
  polt_rsp_if.source rsp
);

  logic      ovalid;
  rsp_word_t word;

  assign res_ready = !ovalid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (res_ready) begin
      ovalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      word <= res;
    end
  end

  assign rsp.valid       = ovalid;
  assign rsp.found       = word.found;
  assign rsp.hit_x       = word.hit_x;
  assign rsp.hit_y       = word.hit_y;
  assign rsp.hit_cost    = word.hit_cost;
  assign rsp.entry_total = word.entry_total;
  assign rsp.status      = word.status;

endmodule

/* rtl/path_open_list_table.sv */
// Path open list table, top level. Depends on polt_pkg, polt_req_if, polt_rsp_if,
// polt_ctrl, polt_outreg and assert_macros.svh.
//
// req carries one command word (opcode, key_x, key_y, cost_f); rsp returns one
// result word per command (found, hit, cost, entry_total, status).
// Both channels use valid/ready; a word moves when both are high at a clock edge.
// One command is in flight at a time: req.ready is high only while idle.
// Append writes its entry on accept unless the table is full; remove and get
// scan every held entry, and find-min scans for the lowest cost below the limit
// and, when one exists, scans again as get with the winning key.
// The next command is accepted the cycle after the previous result leaves the
// sequencer. Scans use a read port and a write port of the entry memory, one
// entry per cycle with a registered read; remove compacts in the same pass.
// The output register lets the next command start while a result waits; a
// finished result then holds in the sequencer until rsp.ready frees the slot.
// Synchronous reset empties the table (entry count zero) and drops any pending
// result; memory contents are not cleared and need no clearing pass.
module path_open_list_table import polt_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  polt_req_if.sink   req,
  polt_rsp_if.source rsp
);

`include "assert_macros.svh"

  rsp_word_t res;
  logic      res_valid, res_ready;

  polt_ctrl #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  polt_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .rsp       (rsp)
  );

  `POLT_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  `POLT_ASSERT_NEXT(a_handoff, res_valid && res_ready, rsp.valid)
  `POLT_ASSERT_IMPL(a_full_total, rsp.valid && rsp.status,
                    rsp.entry_total == TOTAL_W'(CAPACITY))
  `POLT_ASSERT_IMPL(a_miss_zero, rsp.valid && !rsp.found,
                    (rsp.hit_x == '0) && (rsp.hit_y == '0) && (rsp.hit_cost == '0))

endmodule

/* tb/testbench.sv */
// Self-checking testbench for path_open_list_table: directed rows, then random traffic.
// Depends on polt_pkg, polt_req_if, polt_rsp_if and the RTL of the table.
module testbench import polt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 64;
  localparam int ITEMS        = 1150;
  localparam int PAUSE_AT     = 700;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 12;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam logic [KEY_W-1:0]  KEY_MAX  = '1;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_APPEND_ONLY} traffic_mode_t;

  typedef struct {
    op_t                op;
    logic [KEY_W-1:0]   kx;
    logic [KEY_W-1:0]   ky;
    logic [COST_W-1:0]  cf;
    bit                 typed;
    logic               found;
    logic [KEY_W-1:0]   hx;
    logic [KEY_W-1:0]   hy;
    logic [COST_W-1:0]  hc;
    logic [TOTAL_W-1:0] total;
    logic               status;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  polt_req_if req_ch ();
  polt_rsp_if rsp_ch ();

  path_open_list_table DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // model of the table contents
  logic [KEY_W-1:0]  col_mem  [DEPTH];
  logic [KEY_W-1:0]  row_mem  [DEPTH];
  logic [COST_W-1:0] cost_mem [DEPTH];
  int                held;

  rsp_word_t due_results [$];

  int  errors = 0;
  int  cycle = 0;
  int  words_seen = 0;
  bit  calm;
  int  op_count [4];
  int  full_rejects;
  int  min_hits;
  int  min_misses;

  step_row_t directed_plan [24] = '{
    '{OP_GET,    16'h0001, 16'h0002, 31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd0, ST_OK},
    '{OP_MIN,    16'h0000, 16'h0000, 31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd0, ST_OK},
    '{OP_REMOVE, 16'h0003, 16'h0004, 31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd0, ST_OK},
    '{OP_APPEND, 16'h0000, 16'h0000, 31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd1, ST_OK},
    '{OP_APPEND, KEY_MAX,  KEY_MAX,  COST_MAX,     1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd2, ST_OK},
    '{OP_GET,    KEY_MAX,  KEY_MAX,  31'd0,        1, 1'b1, KEY_MAX, KEY_MAX, COST_MAX,
      7'd2, ST_OK},
    '{OP_GET,    16'h0000, 16'h0000, COST_MAX,     1, 1'b1, 16'h0, 16'h0, 31'd0, 7'd2, ST_OK},
    '{OP_MIN,    16'h0000, 16'h0000, 31'd0,        1, 1'b1, 16'h0, 16'h0, 31'd0, 7'd2, ST_OK},
    '{OP_REMOVE, 16'h0000, 16'h0000, 31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd1, ST_OK},
    '{OP_MIN,    16'h0000, 16'h0000, 31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd1, ST_OK},
    '{OP_APPEND, 16'h0005, 16'h0007, COST_LIMIT,   1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd2, ST_OK},
    '{OP_MIN,    16'h0000, 16'h0000, 31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd2, ST_OK},
    '{OP_APPEND, 16'h0005, 16'h0007, COST_LIMIT - 31'd1,
      1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd3, ST_OK},
    '{OP_MIN,    16'h0000, 16'h0000, 31'd0,        0, 1'b0, 16'h0, 16'h0, 31'd0, 7'd0, ST_OK},
    '{OP_APPEND, 16'h0005, 16'h0007, 31'd10,       1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd4, ST_OK},
    '{OP_APPEND, 16'h0000, KEY_MAX,  31'd10,       1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd5, ST_OK},
    '{OP_MIN,    16'h0000, 16'h0000, 31'd0,        0, 1'b0, 16'h0, 16'h0, 31'd0, 7'd0, ST_OK},
    '{OP_GET,    16'h0005, 16'h0007, 31'd0,        0, 1'b0, 16'h0, 16'h0, 31'd0, 7'd0, ST_OK},
    '{OP_REMOVE, 16'h0005, 16'h0007, 31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd2, ST_OK},
    '{OP_GET,    16'h0005, 16'h0007, COST_MAX,     1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd2, ST_OK},
    '{OP_MIN,    16'h0000, 16'h0000, 31'd0,        0, 1'b0, 16'h0, 16'h0, 31'd0, 7'd0, ST_OK},
    '{OP_REMOVE, KEY_MAX,  KEY_MAX,  31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd1, ST_OK},
    '{OP_REMOVE, 16'h0000, KEY_MAX,  31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd0, ST_OK},
    '{OP_MIN,    16'h0000, 16'h0000, 31'd0,        1, 1'b0, 16'h0, 16'h0, 31'd0, 7'd0, ST_OK}
  };

  function automatic rsp_word_t table_apply(op_t op, logic [KEY_W-1:0] kx,
                                            logic [KEY_W-1:0] ky, logic [COST_W-1:0] cf);
    rsp_word_t         r;
    int                w;
    int                mi;
    logic [COST_W-1:0] best;
    bit                have;
    r = '0;
    case (op)
      OP_APPEND: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          col_mem[held]  = kx;
          row_mem[held]  = ky;
          cost_mem[held] = cf;
          held++;
        end
      end
      OP_REMOVE: begin
        w = 0;
        for (int i = 0; i < held; i++) begin
          if (!(col_mem[i] == kx && row_mem[i] == ky)) begin
            col_mem[w]  = col_mem[i];
            row_mem[w]  = row_mem[i];
            cost_mem[w] = cost_mem[i];
            w++;
          end
        end
        held = w;
      end
      default: begin
        have = (op == OP_GET);
        if (op == OP_MIN) begin
          best = COST_LIMIT;
          mi = 0;
          for (int i = 0; i < held; i++) begin
            if (cost_mem[i] < best) begin
              best = cost_mem[i];
              mi = i;
              have = 1'b1;
            end
          end
          if (have) begin
            kx = col_mem[mi];
            ky = row_mem[mi];
          end
        end
        if (have) begin
          for (int i = 0; i < held; i++) begin
            if (col_mem[i] == kx && row_mem[i] == ky) begin
              r.found    = 1'b1;
              r.hit_x    = col_mem[i];
              r.hit_y    = row_mem[i];
              r.hit_cost = cost_mem[i];
              break;
            end
          end
        end
      end
    endcase
    r.entry_total = held[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string text);
    errors++;
    if (errors <= 40) $display("[cycle %0d] word %0d: %s", cycle, words_seen, text);
  endtask

  // drives one command word and queues its expected result once accepted
  task automatic send_word(op_t op, logic [KEY_W-1:0] kx, logic [KEY_W-1:0] ky,
                           logic [COST_W-1:0] cf, bit use_typed, rsp_word_t typed_word);
    rsp_word_t w;
    while (!calm && $urandom_range(99) < 11) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.key_x  <= kx;
    req_ch.key_y  <= ky;
    req_ch.cost_f <= cf;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    w = table_apply(op, kx, ky, cf);
    op_count[op]++;
    if (w.status == ST_FULL) full_rejects++;
    if (op == OP_MIN) begin
      if (w.found) min_hits++;
      else min_misses++;
    end
    due_results.push_back(use_typed ? typed_word : w);
  endtask

  task automatic drain_results();
    if (due_results.size() != 0) begin
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", due_results.size());
      $display("path_open_list_table verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= !rst && (calm || $urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    rsp_word_t got;
    rsp_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.found       = rsp_ch.found;
      got.hit_x       = rsp_ch.hit_x;
      got.hit_y       = rsp_ch.hit_y;
      got.hit_cost    = rsp_ch.hit_cost;
      got.entry_total = rsp_ch.entry_total;
      got.status      = rsp_ch.status;
      if (due_results.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = due_results.pop_front();
        if (got.found !== want.found)
          report_mismatch($sformatf("found %0h, want %0h", got.found, want.found));
        if (got.hit_x !== want.hit_x)
          report_mismatch($sformatf("hit_x %0h, want %0h", got.hit_x, want.hit_x));
        if (got.hit_y !== want.hit_y)
          report_mismatch($sformatf("hit_y %0h, want %0h", got.hit_y, want.hit_y));
        if (got.hit_cost !== want.hit_cost)
          report_mismatch($sformatf("hit_cost %0h, want %0h", got.hit_cost, want.hit_cost));
        if (got.entry_total !== want.entry_total)
          report_mismatch($sformatf("entry_total %0d, want %0d",
                                    got.entry_total, want.entry_total));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0h, want %0h", got.status, want.status));
      end
      words_seen++;
    end
  end

  initial begin
    rsp_word_t         typed_word;
    traffic_mode_t     mode;
    logic [KEY_W-1:0]  pool_x [16];
    logic [KEY_W-1:0]  pool_y [16];
    logic [KEY_W-1:0]  kx;
    logic [KEY_W-1:0]  ky;
    logic [COST_W-1:0] cf;
    op_t               op;
    int                pool_n;
    int                phase_left;
    int                sent;
    int                roll;
    int                pick;

    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.opcode = OP_APPEND;
    req_ch.key_x  = '0;
    req_ch.key_y  = '0;
    req_ch.cost_f = '0;
    held          = 0;
    calm          = 1'b0;
    full_rejects  = 0;
    min_hits      = 0;
    min_misses    = 0;
    foreach (op_count[i]) op_count[i] = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      typed_word.found       = directed_plan[i].found;
      typed_word.hit_x       = directed_plan[i].hx;
      typed_word.hit_y       = directed_plan[i].hy;
      typed_word.hit_cost    = directed_plan[i].hc;
      typed_word.entry_total = directed_plan[i].total;
      typed_word.status      = directed_plan[i].status;
      send_word(directed_plan[i].op, directed_plan[i].kx, directed_plan[i].ky,
                directed_plan[i].cf, directed_plan[i].typed, typed_word);
    end
    sent = $size(directed_plan);

    // random part: phases with their own mix and a small key pool so keys repeat
    typed_word = '0;
    phase_left = 0;
    mode = MODE_APPEND_ONLY;
    pool_n = 1;
    while (sent < ITEMS) begin
      if (phase_left == 0) begin
        if (sent == $size(directed_plan)) begin
          mode = MODE_APPEND_ONLY;
          phase_left = DEPTH + 10;
        end else begin
          mode = traffic_mode_t'($urandom_range(2));
          phase_left = $urandom_range(30, 80);
        end
        pool_n = $urandom_range(2, 16);
        for (int i = 0; i < pool_n; i++) begin
          pool_x[i] = KEY_W'($urandom);
          pool_y[i] = KEY_W'($urandom);
          case ($urandom_range(7))
            0: pool_x[i] = '0;
            1: pool_x[i] = KEY_MAX;
            2: pool_y[i] = '0;
            3: pool_y[i] = KEY_MAX;
            default: ;
          endcase
        end
      end

      roll = $urandom_range(99);
      case (mode)
        MODE_APPEND_ONLY: op = OP_APPEND;
        MODE_FILL:  op = roll < 80 ? OP_APPEND : roll < 88 ? OP_REMOVE :
                         roll < 94 ? OP_GET : OP_MIN;
        MODE_MIXED: op = roll < 40 ? OP_APPEND : roll < 60 ? OP_REMOVE :
                         roll < 80 ? OP_GET : OP_MIN;
        default:    op = roll < 15 ? OP_APPEND : roll < 55 ? OP_REMOVE :
                         roll < 75 ? OP_GET : OP_MIN;
      endcase

      if ($urandom_range(99) < 85) begin
        pick = $urandom_range(pool_n - 1);
        kx = pool_x[pick];
        ky = pool_y[pick];
      end else begin
        kx = KEY_W'($urandom);
        ky = KEY_W'($urandom);
      end

      case ($urandom_range(9))
        0: cf = '0;
        1: cf = COST_MAX;
        2: cf = COST_LIMIT;
        3: cf = COST_LIMIT - 31'd1;
        4: cf = COST_W'($urandom);
        5: cf = COST_LIMIT + 31'($urandom_range(1000000));
        default: cf = 31'($urandom_range(1000));
      endcase

      calm = (sent >= 300 && sent < 500);
      if (sent == PAUSE_AT) drain_results();
      send_word(op, kx, ky, cf, 1'b0, typed_word);
      phase_left--;
      sent++;
    end

    calm = 1'b0;
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("Ran %0d commands: %0d append, %0d remove, %0d get, %0d find-min, %0d words back.",
             sent, op_count[OP_APPEND], op_count[OP_REMOVE], op_count[OP_GET],
             op_count[OP_MIN], words_seen);
    $display("Appends refused on a full table: %0d; find-min hits %0d, misses %0d.",
             full_rejects, min_hits, min_misses);
    if (errors == 0) begin
      $display("path_open_list_table verification clean");
    end else begin
      $display("path_open_list_table verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/polt_pkg.sv
rtl/polt_req_if.sv
rtl/polt_rsp_if.sv
rtl/polt_ctrl.sv
rtl/polt_outreg.sv
rtl/path_open_list_table.sv
tb/testbench.sv
